FILE: rtl/core/hcl_pkg.sv
package hcl_pkg;

  // Line store depth and derived widths
  localparam int MAX_LINE = 32;
  localparam int LEN_W    = $clog2(MAX_LINE + 1);
  localparam int IDX_W    = $clog2(MAX_LINE);

  localparam logic [7:0]       LINE_END_RST = 8'd13;
  localparam logic [7:0]       NUL_CHAR     = 8'h00;
  localparam logic [4:0]       NOT_HEX      = 5'd16;
  localparam logic [LEN_W-1:0] STD_DIGITS   = LEN_W'(3);
  localparam logic [LEN_W-1:0] EXT_DIGITS   = LEN_W'(8);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_ID,
    ST_ACC_ID,
    ST_RD_HI,
    ST_ACC_HI,
    ST_RD_LO,
    ST_ACC_LO,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic acc_id;
    logic acc_hi;
    logic acc_lo;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic end_hit;
    logic line_empty;
    logic frame_ok;
    logic id_done;
    logic id_last;
    logic at_end;
    logic resp;
    logic out_free;
  } status_t;

  // ASCII hex digit value, NOT_HEX for anything else
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39)      v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else                               v = NOT_HEX;
    return v;
  endfunction

endpackage

FILE: rtl/core/hcl_ctrl.sv
module hcl_ctrl
  import hcl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && st.end_hit && !st.line_empty)
          state_next = st.frame_ok ? ST_RD_ID : ST_RD_LO;
      end
      ST_RD_ID:  state_next = ST_ACC_ID;
      ST_ACC_ID: begin
        if (st.id_done) state_next = st.id_last ? ST_EMIT : ST_RD_HI;
        else            state_next = ST_RD_ID;
      end
      ST_RD_HI:  state_next = ST_ACC_HI;
      ST_ACC_HI: state_next = ST_RD_LO;
      ST_RD_LO:  state_next = ST_ACC_LO;
      ST_ACC_LO: state_next = ST_EMIT;
      ST_EMIT: begin
        if (st.out_free) begin
          if (st.at_end)   state_next = ST_IDLE;
          else if (st.resp) state_next = ST_RD_LO;
          else              state_next = ST_RD_HI;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_stall     = (state != ST_IDLE);
    cmd.take     = in_valid && (state == ST_IDLE);
    cmd.acc_id   = (state == ST_ACC_ID);
    cmd.acc_hi   = (state == ST_ACC_HI);
    cmd.acc_lo   = (state == ST_ACC_LO);
    cmd.load_out = (state == ST_EMIT) && st.out_free;
  end

  a_id_only_frame: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC_ID) |-> !st.resp)
    else $error("identifier digit taken in response mode");

  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && st.at_end) |=> (state == ST_IDLE))
    else $error("final beat of line did not return to idle");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> !$past(cmd.take))
    else $error("beat taken while parsing");

endmodule

FILE: rtl/core/hcl_dpath.sv
module hcl_dpath
  import hcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        line_end_char_we,
  input  logic [7:0]  line_end_char,
  input  logic [7:0]  rx_byte,
  input  cmd_t        cmd,
  output status_t     st,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic        is_extended,
  output logic [31:0] can_id,
  output logic [7:0]  data_byte,
  output logic        has_byte,
  output logic        last,
  output logic        overflow
);

  logic [7:0]       end_char;
  logic [7:0]       line_store [MAX_LINE];
  logic [7:0]       rd_data;
  logic [LEN_W-1:0] len_cnt;
  logic             len_ovf;
  logic             saw_nh;

  // Latched line under parse
  logic [LEN_W-1:0] n_chars;
  logic [LEN_W-1:0] ptr;
  logic             ov_w;
  logic             ext_w;
  logic             resp;
  logic [31:0]      id_acc;
  logic [3:0]       hi_nib;
  logic [7:0]       asm_byte;
  logic             asm_has;

  logic [LEN_W-1:0] ptr_inc;
  logic [LEN_W-1:0] id_len;
  logic [LEN_W-1:0] need_len;
  logic [4:0]       rx_hex;
  logic [4:0]       rd_hex;
  logic             is_null;
  logic             is_end;

  assign is_null  = (rx_byte == NUL_CHAR);
  assign is_end   = !is_null && (rx_byte == end_char);
  assign rx_hex   = hex_value(rx_byte);
  assign rd_hex   = hex_value(rd_data);
  assign ptr_inc  = ptr + LEN_W'(1);
  assign id_len   = ext_w ? EXT_DIGITS : STD_DIGITS;
  assign need_len = len_cnt[0] ? STD_DIGITS : EXT_DIGITS;

  always_comb begin
    st.end_hit    = is_end;
    st.line_empty = (len_cnt == '0);
    st.frame_ok   = !saw_nh && (len_cnt >= need_len);
    st.id_done    = (ptr_inc == id_len);
    st.id_last    = (ptr_inc == n_chars);
    st.at_end     = (ptr == n_chars);
    st.resp       = resp;
    st.out_free   = !out_valid || !out_stall;
  end

  // Line end register
  always_ff @(posedge clk) begin
    if (rst)                   end_char <= LINE_END_RST;
    else if (line_end_char_we) end_char <= line_end_char;
  end

  // Line store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.take && !is_null && !is_end && (len_cnt < LEN_W'(MAX_LINE)))
      line_store[len_cnt[IDX_W-1:0]] <= rx_byte;
    rd_data <= line_store[ptr[IDX_W-1:0]];
  end

  // Gathering state
  always_ff @(posedge clk) begin
    if (rst) begin
      len_cnt <= '0;
      len_ovf <= 1'b0;
      saw_nh  <= 1'b0;
    end else if (cmd.take && !is_null) begin
      if (is_end) begin
        len_cnt <= '0;
        len_ovf <= 1'b0;
        saw_nh  <= 1'b0;
      end else if (len_cnt < LEN_W'(MAX_LINE)) begin
        len_cnt <= len_cnt + LEN_W'(1);
        if (rx_hex == NOT_HEX) saw_nh <= 1'b1;
      end else begin
        len_ovf <= 1'b1;
      end
    end
  end

  // Parse registers
  always_ff @(posedge clk) begin
    if (rst) begin
      resp <= 1'b0;
    end else if (cmd.take && is_end) begin
      resp <= !st.frame_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && is_end) begin
      n_chars <= len_cnt;
      ov_w    <= len_ovf;
      ext_w   <= !len_cnt[0];
      ptr     <= '0;
      id_acc  <= '0;
    end
    if (cmd.acc_id) begin
      id_acc  <= {id_acc[27:0], rd_hex[3:0]};
      asm_has <= 1'b0;
      asm_byte <= '0;
      ptr     <= ptr_inc;
    end
    if (cmd.acc_hi) begin
      hi_nib <= rd_hex[3:0];
      ptr    <= ptr_inc;
    end
    if (cmd.acc_lo) begin
      asm_byte <= resp ? rd_data : {hi_nib, rd_hex[3:0]};
      asm_has  <= 1'b1;
      ptr      <= ptr_inc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (!out_stall)   out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind        <= resp;
      is_extended <= !resp && ext_w;
      can_id      <= resp ? 32'd0 : id_acc;
      data_byte   <= asm_byte;
      has_byte    <= asm_has;
      last        <= st.at_end;
      overflow    <= ov_w;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len_cnt <= LEN_W'(MAX_LINE))
    else $error("line length beyond store depth");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> st.out_free)
    else $error("output register overwritten");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.acc_id || cmd.acc_hi || cmd.acc_lo) |-> (ptr < n_chars))
    else $error("read past end of line");

endmodule

FILE: rtl/core/hex_can_line_parser.sv
// Flow: a non-empty line's line-end beat starts the parse; a frame reads and accumulates each
//   identifier digit, then reads and packs each data byte and loads it to the output, or loads once if it has none.
// A response line reads and loads each character in turn. Non line-end beats are taken while idle.
// Throughput: one beat at a time; input is stalled until the line's last result is loaded.
// Each load waits for a free output register; the store's registered read sets the pace.
// Reset (rst, synchronous): line state and handshakes cleared, line end set to 13; no sweep.
module hex_can_line_parser
  import hcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        line_end_char_we,
  input  logic [7:0]  line_end_char,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic        is_extended,
  output logic [31:0] can_id,
  output logic [7:0]  data_byte,
  output logic        has_byte,
  output logic        last,
  output logic        overflow
);

  cmd_t    cmd;
  status_t st;

  hcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  hcl_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .line_end_char_we (line_end_char_we),
    .line_end_char    (line_end_char),
    .rx_byte          (rx_byte),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .is_extended      (is_extended),
    .can_id           (can_id),
    .data_byte        (data_byte),
    .has_byte         (has_byte),
    .last             (last),
    .overflow         (overflow)
  );

endmodule

FILE: tb/tb_hex_can_line_parser.sv
module tb_hex_can_line_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import hcl_pkg::*;

  localparam logic KIND_FRAME    = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;
  localparam int   SETTLE_CYCLES = 120;
  localparam int   DRAIN_GUARD   = 50000;

  typedef struct packed {
    logic        kind;
    logic        is_extended;
    logic [31:0] can_id;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last;
    logic        overflow;
  } parse_result_t;

  typedef enum {LINE_STD, LINE_EXT, LINE_SHORT, LINE_TEXT, LINE_LONG, LINE_EMPTY, LINE_NOISE}
    line_kind_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        line_end_char_we = 1'b0;
  logic [7:0]  line_end_char = LINE_END_RST;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic        is_extended;
  logic [31:0] can_id;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last;
  logic        overflow;

  hex_can_line_parser u_dut (
    .clk              (clk),
    .rst              (rst),
    .line_end_char_we (line_end_char_we),
    .line_end_char    (line_end_char),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .is_extended      (is_extended),
    .can_id           (can_id),
    .data_byte        (data_byte),
    .has_byte         (has_byte),
    .last             (last),
    .overflow         (overflow)
  );

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Line state mirror
  logic [7:0]    line_chars [MAX_LINE];
  int            line_len = 0;
  bit            line_truncated = 1'b0;
  bit            line_has_text = 1'b0;
  logic [7:0]    line_end_now = LINE_END_RST;

  logic [7:0]    pending_chars [$];
  parse_result_t awaited_results [$];
  int            chars_pushed = 0;
  int            gap_pct = 0;
  int            stall_pct = 0;
  int            mismatches = 0;

  // Hex digit value, -1 for anything else
  function automatic int digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR %0t ns: %s", $time, msg);
  endtask

  // Fold one accepted character into the line; at line end, queue what it yields
  task automatic take_char(input logic [7:0] c);
    parse_result_t r;
    int            n;
    int            id_digits;
    int            nbytes;
    int            p;
    bit            ext;
    bit            ov;
    bit            text;
    logic [31:0]   id;
    if (c == NUL_CHAR) return;
    if (c != line_end_now) begin
      if (line_len < MAX_LINE) begin
        line_chars[line_len] = c;
        line_len++;
        if (digit_value(c) < 0) line_has_text = 1'b1;
      end else begin
        line_truncated = 1'b1;
      end
      return;
    end
    n    = line_len;
    ov   = line_truncated;
    text = line_has_text;
    line_len       = 0;
    line_truncated = 1'b0;
    line_has_text  = 1'b0;
    if (n == 0) return;
    ext       = (n % 2 == 0);
    id_digits = ext ? int'(EXT_DIGITS) : int'(STD_DIGITS);
    r = '0;
    r.overflow = ov;
    if (!text && n >= id_digits) begin
      id = '0;
      for (int k = 0; k < id_digits; k++) id = {id[27:0], 4'(digit_value(line_chars[k]))};
      nbytes = (n - id_digits) / 2;
      r.kind        = KIND_FRAME;
      r.is_extended = ext;
      r.can_id      = id;
      if (nbytes == 0) begin
        r.last = 1'b1;
        awaited_results.push_back(r);
      end
      for (int k = 0; k < nbytes; k++) begin
        p = id_digits + 2 * k;
        r.data_byte = {4'(digit_value(line_chars[p])), 4'(digit_value(line_chars[p + 1]))};
        r.has_byte  = 1'b1;
        r.last      = (k == nbytes - 1);
        awaited_results.push_back(r);
      end
    end else begin
      r.kind     = KIND_RESPONSE;
      r.has_byte = 1'b1;
      for (int k = 0; k < n; k++) begin
        r.data_byte = line_chars[k];
        r.last      = (k == n - 1);
        awaited_results.push_back(r);
      end
    end
  endtask

  // Input driver: one beat at a time from pending_chars
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) take_char(rx_byte);
      if (!in_valid || !in_stall) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= pending_chars.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and receiver back-pressure
  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (out_valid && !out_stall) begin
        got = '{kind, is_extended, can_id, data_byte, has_byte, last, overflow};
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result beat %p", got));
        end else begin
          want = awaited_results.pop_front();
          if (got.kind !== want.kind)
            note_mismatch($sformatf("kind %0h, want %0h", got.kind, want.kind));
          if (got.is_extended !== want.is_extended)
            note_mismatch($sformatf("is_extended %0h, want %0h", got.is_extended,
                                    want.is_extended));
          if (got.can_id !== want.can_id)
            note_mismatch($sformatf("can_id %08h, want %08h", got.can_id, want.can_id));
          if (got.data_byte !== want.data_byte)
            note_mismatch($sformatf("data_byte %02h, want %02h", got.data_byte,
                                    want.data_byte));
          if (got.has_byte !== want.has_byte)
            note_mismatch($sformatf("has_byte %0h, want %0h", got.has_byte, want.has_byte));
          if (got.last !== want.last)
            note_mismatch($sformatf("last %0h, want %0h", got.last, want.last));
          if (got.overflow !== want.overflow)
            note_mismatch($sformatf("overflow %0h, want %0h", got.overflow, want.overflow));
        end
      end
    end
  end

  task automatic push_char(input logic [7:0] c);
    pending_chars.push_back(c);
    chars_pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] pick_hex();
    string      digits;
    logic [7:0] c;
    digits = "0123456789ABCDEFabcdef";
    do c = digits[$urandom_range(0, 21)]; while (c == line_end_now);
    return c;
  endfunction

  function automatic logic [7:0] pick_other();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == line_end_now);
    return c;
  endfunction

  // Mostly short payloads, now and then up to the store limit
  function automatic int pick_count(input int max_pairs);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, max_pairs) : $urandom_range(0, 3);
  endfunction

  // One line of the given shape, with stray nulls, closed by the line end unless it is noise
  task automatic queue_line(input line_kind_t shape);
    int         len;
    int         bad_pos;
    bit         mixed;
    logic [7:0] c;
    len   = 0;
    mixed = $urandom_range(0, 1);
    case (shape)
      LINE_STD:   len = STD_DIGITS + 2 * pick_count((MAX_LINE - STD_DIGITS) / 2);
      LINE_EXT:   len = EXT_DIGITS + 2 * pick_count((MAX_LINE - EXT_DIGITS) / 2);
      LINE_SHORT: len = 2 * $urandom_range(0, 3);
      LINE_TEXT:  len = $urandom_range(1, 12);
      LINE_LONG:  len = $urandom_range(MAX_LINE + 1, MAX_LINE + 8);
      LINE_NOISE: len = $urandom_range(1, 6);
      default:    len = 0;
    endcase
    if (shape == LINE_SHORT && len == 0) len = 1;
    bad_pos = $urandom_range(0, (len > 0) ? len - 1 : 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) push_char(NUL_CHAR);
      if (shape == LINE_NOISE) begin
        c = 8'($urandom_range(0, 255));
      end else if (shape == LINE_TEXT && i == bad_pos) begin
        do c = pick_other(); while (digit_value(c) >= 0);
      end else if (shape == LINE_TEXT || (shape == LINE_LONG && mixed)) begin
        c = pick_other();
      end else begin
        c = pick_hex();
      end
      push_char(c);
    end
    if (shape != LINE_NOISE) push_char(line_end_now);
  endtask

  // Random lines, mostly well-formed frames
  task automatic queue_random(input int target);
    int         start;
    int         r;
    line_kind_t shape;
    start = chars_pushed;
    queue_line(LINE_LONG);
    while (chars_pushed - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 35)      shape = LINE_STD;
      else if (r < 60) shape = LINE_EXT;
      else if (r < 68) shape = LINE_SHORT;
      else if (r < 80) shape = LINE_TEXT;
      else if (r < 86) shape = LINE_LONG;
      else if (r < 92) shape = LINE_EMPTY;
      else             shape = LINE_NOISE;
      queue_line(shape);
    end
  endtask

  // Sender holds off until all beats are in and all results are out
  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((pending_chars.size() != 0 || in_valid || awaited_results.size() != 0)
           && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_line_end(input logic [7:0] value);
    @(posedge clk);
    line_end_char_we <= 1'b1;
    line_end_char    <= value;
    @(posedge clk);
    line_end_char_we <= 1'b0;
    line_end_now = value;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    gap_pct   = (mode == IDLE_SEND) ? 87 : (mode == IDLE_BOTH) ? 17 : 0;
    stall_pct = (mode == IDLE_RECV) ? 87 : (mode == IDLE_BOTH) ? 17 : 0;
  endtask

  // Stimulus sequence
  initial begin
    set_idling(IDLE_NONE);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // standard id, no data, with a null inside
    push_text("12");
    push_char(NUL_CHAR);
    push_text("3");
    push_char(line_end_now);
    // empty line
    push_char(line_end_now);
    // extended id at its maximum, one data byte, lower-case digit
    push_text("FFFFFFFFa0");
    push_char(line_end_now);
    // hex line too short for an extended id
    push_text("1B");
    push_char(line_end_now);
    // non-hex response with the top character code
    push_text("O");
    push_char(8'hFF);
    push_char(line_end_now);
    queue_random(80);
    wait_drained();

    write_line_end(8'h0A);
    set_idling(IDLE_SEND);
    queue_random(80);
    wait_drained();

    // null as line end: nothing ever closes a line here
    write_line_end(8'h00);
    set_idling(IDLE_RECV);
    repeat (20) push_char(8'($urandom_range(0, 255)));
    wait_drained();

    write_line_end(8'hFF);
    queue_random(80);
    wait_drained();

    // a hex digit as line end
    write_line_end("5");
    set_idling(IDLE_BOTH);
    queue_random(80);
    wait_drained();

    write_line_end(8'($urandom_range(1, 255)));
    set_idling(IDLE_NONE);
    queue_random(80);
    wait_drained();

    write_line_end(LINE_END_RST);
    set_idling(IDLE_BOTH);
    queue_random(60);
    wait_drained();

    if (awaited_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_500_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
